### design/ilir_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list package
// Shared types and constants for the indexed list and its storage cells.
// ----------------------------------------------------------------------------
package ilir_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned PosW     = 5;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 5;
  localparam int unsigned Capacity = 16;

  typedef enum logic [FuncW-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_INSERT_AT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_POP_FRONT  = 3'd4,
    FN_REMOVE_AT  = 3'd5
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

### design/ilir_cell.sv
// ----------------------------------------------------------------------------
// Indexed list storage cell
// Holds one list entry and moves it toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module ilir_cell import ilir_pkg::*; #(
  parameter int unsigned IdxW = 4,
  parameter int unsigned Idx  = 0
) (
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  input  logic [IdxW-1:0]         pos_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic signed [DataW-1:0] left_i,
  input  logic signed [DataW-1:0] right_i,
  output logic signed [DataW-1:0] data_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic signed [DataW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MyIdx > pos_i) begin
        data_d = left_i;
      end else if (MyIdx == pos_i) begin
        data_d = value_i;
      end
    end else if (cmd_i.del && (MyIdx >= pos_i)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### design/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// Indexed list with insert and remove
// Ordered list of signed values held in a row of shifting storage cells.
// ----------------------------------------------------------------------------
// The input channel carries an operation code, a position and a value. The
// output channel returns one result per operation: status, the count after
// the operation, the value at the front and an empty flag.
// An operation is decoded and applied to every cell in the cycle of its
// transfer; each cell compares its own index with the position and either
// holds, takes its left neighbor, takes its right neighbor or loads the value.
// The result is registered, so it appears in the cycle after the input transfer.
// A new operation is taken in every cycle while the result register is empty
// or being drained, for a throughput of one operation per cycle.
// When the receiver stalls, input ready drops and the list holds still.
// Reset empties the list and drops output valid; the cell contents are not
// cleared, since a cell is read only after it has been written.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove import ilir_pkg::*; #(
  parameter int unsigned CAPACITY = Capacity
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [FuncW-1:0]          func_i,
  input  logic [PosW-1:0]           position_i,
  input  logic signed [DataW-1:0]   value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [StatusW-1:0]        status_o,
  output logic [CountW-1:0]         count_o,
  output logic signed [DataW-1:0]   front_value_o,
  output logic                      is_empty_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  logic              acc;
  logic [CntW-1:0]   occ_d, occ_q;
  logic [CmpW-1:0]   occ_ext, pos_ext;
  logic              full, empty;
  logic              ins, del, dec;
  logic [IdxW-1:0]   pos_eff;
  status_e           status_d, status_q;
  logic              out_valid_q;
  cell_cmd_t         cmd;

  logic signed [DataW-1:0] slot_q [CAPACITY];

  assign acc     = in_valid_i && in_ready_o;
  assign occ_ext = CmpW'(occ_q);
  assign pos_ext = CmpW'(position_i);
  assign full    = (occ_ext == CmpW'(CAPACITY));
  assign empty   = (occ_q == '0);

  always_comb begin
    status_d = ST_OK;
    ins      = 1'b0;
    del      = 1'b0;
    dec      = 1'b0;
    pos_eff  = '0;
    case (func_i)
      FN_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins     = 1'b1;
          pos_eff = occ_ext[IdxW-1:0];
        end
      end
      FN_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ins = 1'b1;
        end
      end
      FN_INSERT_AT: begin
        if (pos_ext > occ_ext) begin
          status_d = ST_BAD_INDEX;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ins     = 1'b1;
          pos_eff = pos_ext[IdxW-1:0];
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          dec = 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          del = 1'b1;
        end
      end
      FN_REMOVE_AT: begin
        if (pos_ext >= occ_ext) begin
          status_d = ST_BAD_INDEX;
        end else begin
          del     = 1'b1;
          pos_eff = pos_ext[IdxW-1:0];
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign cmd.ins = acc && ins;
  assign cmd.del = acc && del;

  always_comb begin
    occ_d = occ_q;
    if (acc && ins) begin
      occ_d = occ_q + CntW'(1);
    end else if (acc && (del || dec)) begin
      occ_d = occ_q - CntW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = value_i;
    end else begin : g_mid_l
      assign left = slot_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = slot_q[i];
    end else begin : g_mid_r
      assign right = slot_q[i+1];
    end
    ilir_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos_eff),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (slot_q[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
    end
  end

  assign in_ready_o    = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign count_o       = occ_ext[CountW-1:0];
  assign front_value_o = empty ? '0 : slot_q[0];
  assign is_empty_o    = empty;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_ext <= CmpW'(CAPACITY))
    else $error("list count exceeds capacity");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(occ_q) && $stable(status_q))
    else $error("list changed while the result was stalled");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (occ_q == $past(occ_q) + CntW'(1)) && (status_q == ST_OK))
    else $error("insert did not grow the list");

  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (status_d != ST_OK)) |=> $stable(occ_q))
    else $error("failed operation changed the count");
`endif

endmodule
